@@ design/edfq_pkg.sv @@
package edfq_pkg;

    // Cache geometry default
    localparam int EDFQ_CACHE_DEPTH = 16;

    // Field widths
    localparam int STAMP_W = 24;
    localparam int CODE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int SIG_W   = STAMP_W + CODE_W;

    localparam logic [TIME_W-1:0] CONFIRM_DEFAULT = TIME_W'(2000);

    // Request kinds
    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Shared unit operations
    localparam logic OP_EQ  = 1'b0;
    localparam logic OP_AGE = 1'b1;

    // Recoverable fault slots
    localparam logic [1:0] F_TEMP  = 2'd0;
    localparam logic [1:0] F_CURR  = 2'd1;
    localparam logic [1:0] F_UNDER = 2'd2;
    localparam logic [1:0] F_OVER  = 2'd3;

    // Event codes
    localparam logic [CODE_W-1:0] EV_SW_0      = 8'h0B;
    localparam logic [CODE_W-1:0] EV_SW_1      = 8'h0C;
    localparam logic [CODE_W-1:0] EV_SW_2      = 8'h0D;
    localparam logic [CODE_W-1:0] EV_TEMP_SET  = 8'h04;
    localparam logic [CODE_W-1:0] EV_TEMP_CLR  = 8'h73;
    localparam logic [CODE_W-1:0] EV_CURR_SET0 = 8'h05;
    localparam logic [CODE_W-1:0] EV_CURR_SET1 = 8'h06;
    localparam logic [CODE_W-1:0] EV_CURR_SET2 = 8'h07;
    localparam logic [CODE_W-1:0] EV_CURR_CLR0 = 8'h76;
    localparam logic [CODE_W-1:0] EV_CURR_CLR1 = 8'h77;
    localparam logic [CODE_W-1:0] EV_CURR_CLR2 = 8'h78;
    localparam logic [CODE_W-1:0] EV_UNDER_SET = 8'h02;
    localparam logic [CODE_W-1:0] EV_UNDER_CLR = 8'h7B;
    localparam logic [CODE_W-1:0] EV_OVER_SET  = 8'h03;
    localparam logic [CODE_W-1:0] EV_OVER_CLR  = 8'h79;

    typedef struct packed {
        logic       set_sw;
        logic       arm;
        logic       clr;
        logic [1:0] fault;
    } t_action;

    // Map an event code to its effect on the fault state
    function automatic t_action decode_code(input logic [CODE_W-1:0] code);
        t_action act;
        act = '0;
        if (code inside {EV_SW_0, EV_SW_1, EV_SW_2}) begin
            act.set_sw = 1'b1;
        end else if (code == EV_TEMP_SET) begin
            act.arm   = 1'b1;
            act.fault = F_TEMP;
        end else if (code == EV_TEMP_CLR) begin
            act.clr   = 1'b1;
            act.fault = F_TEMP;
        end else if (code inside {EV_CURR_SET0, EV_CURR_SET1, EV_CURR_SET2}) begin
            act.arm   = 1'b1;
            act.fault = F_CURR;
        end else if (code inside {EV_CURR_CLR0, EV_CURR_CLR1, EV_CURR_CLR2}) begin
            act.clr   = 1'b1;
            act.fault = F_CURR;
        end else if (code == EV_UNDER_SET) begin
            act.arm   = 1'b1;
            act.fault = F_UNDER;
        end else if (code == EV_UNDER_CLR) begin
            act.clr   = 1'b1;
            act.fault = F_UNDER;
        end else if (code == EV_OVER_SET) begin
            act.arm   = 1'b1;
            act.fault = F_OVER;
        end else if (code == EV_OVER_CLR) begin
            act.clr   = 1'b1;
            act.fault = F_OVER;
        end
        return act;
    endfunction

endpackage

@@ design/edfq_req_if.sv @@
interface edfq_req_if
    import edfq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [STAMP_W-1:0] event_stamp;
    logic [CODE_W-1:0] event_code;
    logic [TIME_W-1:0] now_time_ms;

    modport source (output valid, req_type, event_stamp, event_code, now_time_ms,
                    input ready);
    modport sink   (input valid, req_type, event_stamp, event_code, now_time_ms,
                    output ready);
endinterface

@@ design/edfq_rsp_if.sv @@
interface edfq_rsp_if
    import edfq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              duplicate_seen;
    logic              switch_fault;
    logic              over_temp;
    logic              over_current;
    logic              under_voltage;
    logic              over_voltage;
    logic [CODE_W-1:0] latest_code;

    modport source (output valid, duplicate_seen, switch_fault, over_temp, over_current,
                           under_voltage, over_voltage, latest_code,
                    input ready);
    modport sink   (input valid, duplicate_seen, switch_fault, over_temp, over_current,
                          under_voltage, over_voltage, latest_code,
                    output ready);
endinterface

@@ design/edfq_cfg_if.sv @@
interface edfq_cfg_if
    import edfq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/edfq_ram.sv @@
module edfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/edfq_alu.sv @@
module edfq_alu
    import edfq_pkg::*;
(
    input  logic              i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    input  logic [TIME_W-1:0] i_c,
    output logic              o_hit
);

    logic [TIME_W-1:0] diff;

    // Equality for the cache scan, wrapping age compare for fault promotion
    always_comb begin
        diff = i_a - i_b;
        case (i_op)
            OP_EQ:   o_hit = (i_a == i_b);
            OP_AGE:  o_hit = (diff >= i_c);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

@@ design/event_dedup_fault_qualifier_unit.sv @@
// Event dedup and fault qualifier.
// i_req carries one item per beat: an event (stamp, code) or a tick (now_time_ms).
// o_rsp returns exactly one result beat per request beat, in order.
// i_cfg writes confirm_time_ms (a zero write selects 2000 ms); it is always ready
// and must only be used while the block is idle.
// An event scans the signature cache one entry per cycle through the cache RAM's
// single registered read port, and stops early when a duplicate hits.
// A tick walks the four recoverable faults through the shared age comparator.
// i_req.ready is high only while no item is in work, so one item is handled at
// a time; the block returns to idle when it loads a result, and takes the next
// beat there.
// The result sits in an output register; while the receiver stalls the next item
// may still be taken, and the block holds its new result until the old one leaves.
// Reset clears fill count, ring head, all fault flags, the last code and the
// confirm time (2000 ms). Cache contents need no clearing: only the first fill
// entries are ever compared.
module event_dedup_fault_qualifier_unit
    import edfq_pkg::*;
#(
    parameter int CACHE_DEPTH = EDFQ_CACHE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    edfq_req_if.sink   i_req,
    edfq_cfg_if.sink   i_cfg,
    edfq_rsp_if.source o_rsp
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [TIME_W-1:0] r_confirm, n_confirm;
    logic [SIG_W-1:0]  r_sig, n_sig;
    logic [CODE_W-1:0] r_code, n_code;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [1:0]        r_fidx, n_fidx;
    logic              r_dup, n_dup;
    logic [3:0]        r_pend, n_pend;
    logic [3:0]        r_act, n_act;
    logic [TIME_W-1:0] r_since [4];
    logic [TIME_W-1:0] n_since [4];
    logic              r_sw, n_sw;
    logic [CODE_W-1:0] r_last, n_last;

    logic              r_out_valid, n_out_valid;
    logic              r_out_dup, n_out_dup;
    logic              r_out_sw, n_out_sw;
    logic [3:0]        r_out_act, n_out_act;
    logic [CODE_W-1:0] r_out_code, n_out_code;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic              ram_rd_en;
    logic [SIG_W-1:0]  ram_rd_data;
    logic              alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic              alu_hit;
    logic              cache_full;
    logic              scan_issue;
    t_action           action;

    // Signature cache storage
    edfq_ram #(
        .WIDTH (SIG_W),
        .DEPTH (CACHE_DEPTH)
    ) u_cache (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_sig),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Shared compare unit
    edfq_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (r_confirm),
        .o_hit (alu_hit)
    );

    assign cache_full  = (r_fill == CW'(CACHE_DEPTH));
    assign scan_issue  = (r_idx < r_fill);
    assign ram_wr_addr = cache_full ? r_head : r_fill[AW-1:0];
    assign action      = decode_code(r_code);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.duplicate_seen = r_out_dup;
    assign o_rsp.switch_fault   = r_out_sw;
    assign o_rsp.over_temp      = r_out_act[F_TEMP];
    assign o_rsp.over_current   = r_out_act[F_CURR];
    assign o_rsp.under_voltage  = r_out_act[F_UNDER];
    assign o_rsp.over_voltage   = r_out_act[F_OVER];
    assign o_rsp.latest_code    = r_out_code;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_confirm   = r_confirm;
        n_sig       = r_sig;
        n_code      = r_code;
        n_now       = r_now;
        n_fill      = r_fill;
        n_head      = r_head;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_fidx      = r_fidx;
        n_dup       = r_dup;
        n_pend      = r_pend;
        n_act       = r_act;
        n_since     = r_since;
        n_sw        = r_sw;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_dup   = r_out_dup;
        n_out_sw    = r_out_sw;
        n_out_act   = r_out_act;
        n_out_code  = r_out_code;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        alu_op      = OP_EQ;
        alu_a       = ram_rd_data;
        alu_b       = r_sig;

        // config write
        if (i_cfg.valid) begin
            n_confirm = (i_cfg.data == '0) ? CONFIRM_DEFAULT : i_cfg.data;
        end

        // result beat leaves
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_sig     = {i_req.event_stamp, i_req.event_code};
                    n_code    = i_req.event_code;
                    n_now     = i_req.now_time_ms;
                    n_dup     = 1'b0;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_fidx    = F_TEMP;
                    if (i_req.req_type == REQ_EVENT) begin
                        n_last  = i_req.event_code;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_TICK;
                    end
                end
            end
            S_SCAN: begin
                // one read issued and one compare done per cycle
                if (r_cmp_vld && alu_hit) begin
                    n_dup     = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_state   = S_FIN;
                end else if (!scan_issue && !r_cmp_vld) begin
                    n_state = S_WRITE;
                end else begin
                    ram_rd_en = scan_issue;
                    n_idx     = r_idx + CW'(scan_issue);
                    n_cmp_vld = scan_issue;
                end
            end
            S_WRITE: begin
                // store new signature, then apply the code
                ram_wr_en = 1'b1;
                if (cache_full) begin
                    n_head = (r_head == AW'(CACHE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                end else begin
                    n_fill = r_fill + CW'(1);
                end
                if (action.set_sw) begin
                    n_sw = 1'b1;
                end
                if (action.arm && !r_pend[action.fault] && !r_act[action.fault]) begin
                    n_pend[action.fault]  = 1'b1;
                    n_since[action.fault] = r_now;
                end
                if (action.clr) begin
                    n_pend[action.fault]  = 1'b0;
                    n_act[action.fault]   = 1'b0;
                    n_since[action.fault] = '0;
                end
                n_state = S_FIN;
            end
            S_TICK: begin
                // promote one pending fault per cycle
                alu_op = OP_AGE;
                alu_a  = r_now;
                alu_b  = r_since[r_fidx];
                if (r_pend[r_fidx] && !r_act[r_fidx] && alu_hit) begin
                    n_pend[r_fidx] = 1'b0;
                    n_act[r_fidx]  = 1'b1;
                end
                if (r_fidx == F_OVER) begin
                    n_state = S_FIN;
                end else begin
                    n_fidx = r_fidx + 2'd1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dup   = r_dup;
                    n_out_sw    = r_sw;
                    n_out_act   = r_act;
                    n_out_code  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_confirm   <= CONFIRM_DEFAULT;
            r_fill      <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_fidx      <= F_TEMP;
            r_pend      <= '0;
            r_act       <= '0;
            r_sw        <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_since[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_confirm   <= n_confirm;
            r_fill      <= n_fill;
            r_head      <= n_head;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_fidx      <= n_fidx;
            r_pend      <= n_pend;
            r_act       <= n_act;
            r_sw        <= n_sw;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_since     <= n_since;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_sig      <= n_sig;
        r_code     <= n_code;
        r_now      <= n_now;
        r_dup      <= n_dup;
        r_out_dup  <= n_out_dup;
        r_out_sw   <= n_out_sw;
        r_out_act  <= n_out_act;
        r_out_code <= n_out_code;
    end

    // Checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CACHE_DEPTH))
        else $error("cache fill count beyond depth");

    a_head_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cache_full |-> (r_head == '0))
        else $error("ring head moved before cache filled");

    a_pend_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & r_act) == 4'b0)
        else $error("fault both pending and active");

    a_sw_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw |=> r_sw)
        else $error("switch fault flag dropped");

endmodule

@@ tb/tb_event_dedup_fault_qualifier_unit.sv @@
`timescale 1ns / 1ps

module tb_event_dedup_fault_qualifier_unit;
    import edfq_pkg::*;

    typedef struct packed {
        logic               req_type;
        logic [STAMP_W-1:0] event_stamp;
        logic [CODE_W-1:0]  event_code;
        logic [TIME_W-1:0]  now_time_ms;
    } req_t;

    typedef struct packed {
        logic              duplicate_seen;
        logic              switch_fault;
        logic              over_temp;
        logic              over_current;
        logic              under_voltage;
        logic              over_voltage;
        logic [CODE_W-1:0] latest_code;
    } flags_t;

    localparam int DEPTH = EDFQ_CACHE_DEPTH;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drivers of the channels
    logic              tx_valid  = 1'b0;
    req_t              tx_item   = '0;
    logic              rx_ready  = 1'b0;
    logic              rx_block  = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [TIME_W-1:0] cfg_data  = '0;

    edfq_req_if req_bus ();
    edfq_cfg_if cfg_bus ();
    edfq_rsp_if rsp_bus ();

    assign req_bus.valid       = tx_valid;
    assign req_bus.req_type    = tx_item.req_type;
    assign req_bus.event_stamp = tx_item.event_stamp;
    assign req_bus.event_code  = tx_item.event_code;
    assign req_bus.now_time_ms = tx_item.now_time_ms;
    assign rsp_bus.ready       = rx_ready;
    assign cfg_bus.valid       = cfg_valid;
    assign cfg_bus.data        = cfg_data;

    event_dedup_fault_qualifier_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [SIG_W-1:0]  sig_mem [DEPTH];
    int                sig_fill   = 0;
    int                sig_head   = 0;
    logic              pend [4]   = '{default: 1'b0};
    logic              act [4]    = '{default: 1'b0};
    logic [TIME_W-1:0] since [4]  = '{default: '0};
    logic              sw_flag    = 1'b0;
    logic [CODE_W-1:0] last_code  = '0;
    logic [TIME_W-1:0] confirm_ms = CONFIRM_DEFAULT;

    req_t   pending_q [$];
    flags_t flags_q [$];
    int     errors = 0;

    // Stimulus bookkeeping
    logic [TIME_W-1:0]  now_ms = '0;
    logic [STAMP_W-1:0] stamp_pool [4];
    logic [SIG_W-1:0]   recent_q [$];
    logic [CODE_W-1:0]  fault_codes [15];
    bit                 hold_go = 1'b0;

    int tx_gap    = 0;
    int calm_tx   = 0;
    int calm_rx   = 0;
    int stall_left = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 100)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Work out the flags one accepted beat produces and queue them
    task automatic qualify(input req_t it);
        flags_t            r;
        logic [SIG_W-1:0]  sig;
        logic [TIME_W-1:0] age;
        bit                hit;
        int                arm_slot;
        int                clr_slot;
        r        = '0;
        arm_slot = -1;
        clr_slot = -1;
        if (it.req_type == REQ_EVENT) begin
            sig       = {it.event_stamp, it.event_code};
            last_code = it.event_code;
            hit       = 1'b0;
            for (int k = 0; k < sig_fill; k++) begin
                if (sig_mem[k] == sig) hit = 1'b1;
            end
            if (hit) begin
                r.duplicate_seen = 1'b1;
            end else begin
                // fill in order, then overwrite oldest in ring order
                if (sig_fill < DEPTH) begin
                    sig_mem[sig_fill] = sig;
                    sig_fill++;
                end else begin
                    sig_mem[sig_head] = sig;
                    sig_head = (sig_head + 1) % DEPTH;
                end
                case (it.event_code)
                    EV_SW_0, EV_SW_1, EV_SW_2: sw_flag = 1'b1;
                    EV_TEMP_SET: arm_slot = F_TEMP;
                    EV_TEMP_CLR: clr_slot = F_TEMP;
                    EV_CURR_SET0, EV_CURR_SET1, EV_CURR_SET2: arm_slot = F_CURR;
                    EV_CURR_CLR0, EV_CURR_CLR1, EV_CURR_CLR2: clr_slot = F_CURR;
                    EV_UNDER_SET: arm_slot = F_UNDER;
                    EV_UNDER_CLR: clr_slot = F_UNDER;
                    EV_OVER_SET:  arm_slot = F_OVER;
                    EV_OVER_CLR:  clr_slot = F_OVER;
                    default: ;
                endcase
                // re-arm while pending or active keeps the original time
                if (arm_slot >= 0 && !pend[arm_slot] && !act[arm_slot]) begin
                    pend[arm_slot]  = 1'b1;
                    since[arm_slot] = it.now_time_ms;
                end
                if (clr_slot >= 0) begin
                    pend[clr_slot]  = 1'b0;
                    act[clr_slot]   = 1'b0;
                    since[clr_slot] = '0;
                end
            end
        end else begin
            // tick: promote faults pending long enough, wrapping elapsed time
            for (int k = 0; k < 4; k++) begin
                age = it.now_time_ms - since[k];
                if (pend[k] && !act[k] && age >= confirm_ms) begin
                    pend[k] = 1'b0;
                    act[k]  = 1'b1;
                end
            end
        end
        r.switch_fault  = sw_flag;
        r.over_temp     = act[F_TEMP];
        r.over_current  = act[F_CURR];
        r.under_voltage = act[F_UNDER];
        r.over_voltage  = act[F_OVER];
        r.latest_code   = last_code;
        flags_q.push_back(r);
    endtask

    // Mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (tx_valid && req_bus.ready) begin
                qualify(tx_item);
                tx_gap = pick_gap(calm_tx);
            end
            if (tx_valid && !req_bus.ready) begin
                // hold the beat until taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                tx_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                tx_item  <= pending_q.pop_front();
                tx_valid <= 1'b1;
            end else begin
                tx_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin : rsp_monitor
        flags_t want;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_bus.valid && rx_ready) begin
                if (flags_q.size() == 0) begin
                    report_mismatch("result with nothing expected", rsp_bus.latest_code, 8'h00);
                end else begin
                    want = flags_q.pop_front();
                    if (rsp_bus.duplicate_seen !== want.duplicate_seen)
                        report_mismatch("duplicate_seen", rsp_bus.duplicate_seen,
                                        want.duplicate_seen);
                    if (rsp_bus.switch_fault !== want.switch_fault)
                        report_mismatch("switch_fault", rsp_bus.switch_fault, want.switch_fault);
                    if (rsp_bus.over_temp !== want.over_temp)
                        report_mismatch("over_temp", rsp_bus.over_temp, want.over_temp);
                    if (rsp_bus.over_current !== want.over_current)
                        report_mismatch("over_current", rsp_bus.over_current, want.over_current);
                    if (rsp_bus.under_voltage !== want.under_voltage)
                        report_mismatch("under_voltage", rsp_bus.under_voltage,
                                        want.under_voltage);
                    if (rsp_bus.over_voltage !== want.over_voltage)
                        report_mismatch("over_voltage", rsp_bus.over_voltage, want.over_voltage);
                    if (rsp_bus.latest_code !== want.latest_code)
                        report_mismatch("latest_code", rsp_bus.latest_code, want.latest_code);
                end
            end
            if (rx_block) begin
                rx_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall_left = pick_gap(calm_rx);
            end
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_block <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_block <= 1'b0;
    end

    task automatic push_item(input logic kind, input logic [STAMP_W-1:0] stamp,
                             input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now);
        req_t it;
        it.req_type    = kind;
        it.event_stamp = stamp;
        it.event_code  = code;
        it.now_time_ms = now;
        pending_q.push_back(it);
    endtask

    // Random beats: ticks, replays of recent signatures, and fresh events
    task automatic push_random(input int unsigned step_max);
        req_t             it;
        logic [SIG_W-1:0] sig;
        int               r;
        r              = $urandom_range(0, 99);
        it.event_stamp = STAMP_W'($urandom);
        it.event_code  = CODE_W'($urandom);
        if (r < 30) begin
            now_ms         = now_ms + $urandom_range(0, step_max);
            it.req_type    = REQ_TICK;
            it.now_time_ms = ($urandom_range(0, 99) < 8) ? TIME_W'($urandom) : now_ms;
        end else begin
            it.req_type = REQ_EVENT;
            if (r < 45 && recent_q.size() > 0) begin
                sig = recent_q[$urandom_range(0, recent_q.size() - 1)];
                {it.event_stamp, it.event_code} = sig;
            end else begin
                if ($urandom_range(0, 1)) it.event_stamp = stamp_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 99) < 65) it.event_code = fault_codes[$urandom_range(0, 14)];
            end
            now_ms         = now_ms + $urandom_range(0, step_max / 4);
            it.now_time_ms = ($urandom_range(0, 99) < 5) ? TIME_W'($urandom) : now_ms;
            recent_q.push_back({it.event_stamp, it.event_code});
            if (recent_q.size() > 24) void'(recent_q.pop_front());
        end
        pending_q.push_back(it);
    endtask

    task automatic fill_random(input int unsigned step_max, input int n);
        for (int s = 0; s < 4; s++) stamp_pool[s] = STAMP_W'($urandom);
        repeat (n) push_random(step_max);
    endtask

    // Sender pauses until every result is back, then lets the block settle
    task automatic wait_idle();
        while (pending_q.size() != 0 || tx_valid || flags_q.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_confirm(input logic [TIME_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        confirm_ms = (value == '0) ? CONFIRM_DEFAULT : value;
    endtask

    // Stimulus
    initial begin
        logic [TIME_W-1:0] rnd_confirm;
        fault_codes = '{EV_SW_0, EV_SW_1, EV_SW_2, EV_TEMP_SET, EV_TEMP_CLR,
                        EV_CURR_SET0, EV_CURR_SET1, EV_CURR_SET2,
                        EV_CURR_CLR0, EV_CURR_CLR1, EV_CURR_CLR2,
                        EV_UNDER_SET, EV_UNDER_CLR, EV_OVER_SET, EV_OVER_CLR};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed at reset defaults: field extremes, duplicates, every code
        push_item(REQ_EVENT, 24'h000000, 8'h00, 32'h0000_0000);
        push_item(REQ_EVENT, 24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF);
        push_item(REQ_EVENT, 24'hFFFFFF, 8'hFF, 32'h0000_0000);
        push_item(REQ_TICK,  24'hFFFFFF, 8'hFF, 32'h0000_0000);
        push_item(REQ_EVENT, 24'h000001, EV_TEMP_SET, 32'd1000);
        push_item(REQ_EVENT, 24'h000002, EV_TEMP_SET, 32'd1500);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd2999);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd3000);
        push_item(REQ_EVENT, 24'h000003, EV_TEMP_SET, 32'd3100);
        // overcurrent armed just before the time wraps
        push_item(REQ_EVENT, 24'h000004, EV_CURR_SET1, 32'hFFFF_FC00);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'h0000_03CF);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'h0000_03D0);
        push_item(REQ_EVENT, 24'h000001, EV_TEMP_SET, 32'd0);
        push_item(REQ_EVENT, 24'h000005, EV_TEMP_CLR, 32'd4000);
        push_item(REQ_EVENT, 24'h000006, EV_SW_0, 32'd10);
        push_item(REQ_EVENT, 24'h000007, EV_SW_1, 32'd10);
        push_item(REQ_EVENT, 24'h000008, EV_SW_2, 32'd10);
        push_item(REQ_EVENT, 24'h000009, EV_UNDER_SET, 32'd10);
        push_item(REQ_EVENT, 24'h00000A, EV_OVER_SET, 32'd10);
        push_item(REQ_EVENT, 24'h00000B, EV_CURR_SET0, 32'd10);
        push_item(REQ_EVENT, 24'h00000C, EV_CURR_SET2, 32'd10);
        push_item(REQ_EVENT, 24'h00000D, EV_CURR_CLR0, 32'd10);
        push_item(REQ_EVENT, 24'h00000E, EV_CURR_CLR1, 32'd10);
        push_item(REQ_EVENT, 24'h00000F, EV_CURR_CLR2, 32'd10);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd5000);
        push_item(REQ_EVENT, 24'h000010, EV_UNDER_CLR, 32'd5000);
        push_item(REQ_EVENT, 24'h000011, EV_OVER_CLR, 32'd5000);
        wait_idle();

        // Zero write falls back to the default; long receiver hold-off here
        write_confirm('0);
        fill_random(600, 400);
        hold_go = 1'b1;
        wait_idle();

        // Shortest confirm time
        write_confirm(32'd1);
        now_ms = 32'd50;
        push_item(REQ_EVENT, 24'h0A0A0A, EV_TEMP_SET, 32'd50);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd50);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd51);
        push_item(REQ_EVENT, 24'h0A0A0B, EV_TEMP_CLR, 32'd52);
        fill_random(3, 300);
        wait_idle();

        // Longest confirm time: only an elapsed of all ones promotes
        write_confirm(32'hFFFF_FFFF);
        push_item(REQ_EVENT, 24'h5A5A5A, EV_UNDER_CLR, 32'd0);
        push_item(REQ_EVENT, 24'h5A5A5B, EV_OVER_CLR, 32'd0);
        push_item(REQ_EVENT, 24'h5A5A5C, EV_UNDER_SET, 32'd100);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd99);
        push_item(REQ_EVENT, 24'h5A5A5D, EV_OVER_SET, 32'd5);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd3);
        push_item(REQ_TICK,  24'h000000, 8'h00, 32'd4);
        fill_random(32'h4000_0000, 200);
        wait_idle();

        // Random confirm time
        rnd_confirm = $urandom_range(1, 100000);
        write_confirm(rnd_confirm);
        fill_random(rnd_confirm / 3 + 1, 400);
        wait_idle();

        // Back to the nominal value
        write_confirm(32'd2000);
        fill_random(800, 400);
        wait_idle();

        repeat (30) @(posedge i_clk);
        if (errors == 0 && flags_q.size() == 0) begin
            $display("tb_event_dedup_fault_qualifier_unit passed");
        end else begin
            $display("tb_event_dedup_fault_qualifier_unit failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("tb_event_dedup_fault_qualifier_unit failed");
        $finish;
    end

endmodule
